### rtl/frame_cadence_governor_unit_defines.svh
`ifndef FRAME_CADENCE_GOVERNOR_UNIT_DEFINES_SVH
`define FRAME_CADENCE_GOVERNOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fcg_pkg.sv
package fcg_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 20;

   localparam logic [CsrIndexWidth-1:0] CSR_FLOOR_PERIOD = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GOV_ENABLE   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LATE_RATIO   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_EARLY_RATIO  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_LATE_FRAMES  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_EARLY_FRAMES = 3'd5;

   localparam logic MODE_PRESENT = 1'b0;
   localparam logic MODE_DECIDE  = 1'b1;

   localparam logic [31:0] LongGapUs = 32'd250000;
   // floor(2^32 / 10)
   localparam logic [28:0] RecipTen  = 29'd429496729;
   localparam logic [7:0]  RunMax    = 8'hFF;
   localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        mode;
      logic        time_valid;
      logic [31:0] timestamp_us;
      logic [23:0] last_delay_us;
      logic [31:0] frame_ordinal;
   } req_type;

   typedef struct packed {
      logic        allow;
      logic [3:0]  step;
      logic        step_changed;
      logic        below_floor;
      logic [23:0] frame_average;
      logic [31:0] present_number;
      logic [31:0] thinned_count;
   } rsp_type;

endpackage

### rtl/fcg_req_if.sv
interface fcg_req_if;
   import fcg_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/fcg_rsp_if.sv
interface fcg_rsp_if;
   import fcg_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/fcg_csr_if.sv
interface fcg_csr_if;
   import fcg_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/frame_cadence_governor_unit.sv
// Frame cadence governor. Accepts one item per clock on req_chan unless rsp_chan stalls, and
// returns exactly one result per item on rsp_chan via the input register, then the result
// register; the result register lets the next item enter while a result waits. Present items
// update a smoothed frame time (1/16 us) from timestamp deltas; decide items answer whether a
// generated frame gets a companion, using a floor with hysteresis and a late/early streak
// governor whose step thins companions to ordinals divisible by the step. The sustained rate
// is one item per cycle, set by the single registered pass that feeds the updated state back
// to the next item. Register writes on csr_chan are always taken and apply from the next cycle.
`include "frame_cadence_governor_unit_defines.svh"

module frame_cadence_governor_unit #(
   parameter int MAX_STEP = 3
) (
   input logic        clock,
   input logic        reset,
   fcg_req_if.sink    req_chan,
   fcg_rsp_if.source  rsp_chan,
   fcg_csr_if.sink    csr_chan
);
   import fcg_pkg::*;

   localparam logic [3:0] MaxStep = 4'(MAX_STEP);

   // configuration
   logic [19:0] floor_period_ff;
   logic        gov_enable_ff;
   logic [9:0]  late_ratio_ff;
   logic [9:0]  early_ratio_ff;
   logic [7:0]  late_frames_ff;
   logic [7:0]  early_frames_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_period_ff <= '0;
         gov_enable_ff   <= 1'b1;
         late_ratio_ff   <= 10'd230;
         early_ratio_ff  <= 10'd128;
         late_frames_ff  <= 8'd3;
         early_frames_ff <= 8'd30;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FLOOR_PERIOD: floor_period_ff <= csr_chan.data[19:0];
            CSR_GOV_ENABLE:   gov_enable_ff   <= csr_chan.data[0];
            CSR_LATE_RATIO:   late_ratio_ff   <= csr_chan.data[9:0];
            CSR_EARLY_RATIO:  early_ratio_ff  <= csr_chan.data[9:0];
            CSR_LATE_FRAMES:  late_frames_ff  <= csr_chan.data[7:0];
            CSR_EARLY_FRAMES: early_frames_ff <= csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   // input and result registers
   req_type item_ff;
   logic    item_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    advance;

   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            item_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // state
   logic [31:0] last_time_ff,  last_time_in;
   logic        seen_ff,       seen_in;
   logic [23:0] avg_ff,        avg_in;
   logic [31:0] presents_ff,   presents_in;
   logic        floor_flag_ff, floor_flag_in;
   logic [7:0]  late_run_ff,   late_run_in;
   logic [7:0]  early_run_ff,  early_run_in;
   logic [3:0]  gov_step_ff,   gov_step_in;
   logic [31:0] denied_ff,     denied_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff  <= '0;
         seen_ff       <= 1'b0;
         avg_ff        <= '0;
         presents_ff   <= '0;
         floor_flag_ff <= 1'b0;
         late_run_ff   <= '0;
         early_run_ff  <= '0;
         gov_step_ff   <= '0;
         denied_ff     <= '0;
      end else begin
         last_time_ff  <= last_time_in;
         seen_ff       <= seen_in;
         avg_ff        <= avg_in;
         presents_ff   <= presents_in;
         floor_flag_ff <= floor_flag_in;
         late_run_ff   <= late_run_in;
         early_run_ff  <= early_run_in;
         gov_step_ff   <= gov_step_in;
         denied_ff     <= denied_in;
      end
   end

   // average update: (avg * 9 + dt) / 10 by reciprocal with one correction
   logic [31:0] dt_us;
   logic [21:0] dt_full;
   logic [24:0] two_avg;
   logic [21:0] dt_clamped;
   logic [27:0] sum9;
   logic [56:0] q_prod;
   logic [24:0] q_est;
   logic [27:0] q_tens;
   logic [27:0] q_rem;
   logic [24:0] q_fix;
   logic [23:0] avg_upd;

   assign dt_us      = item_ff.timestamp_us - last_time_ff;
   assign dt_full    = {dt_us[17:0], 4'b0000};
   assign two_avg    = {avg_ff, 1'b0};
   assign dt_clamped = (avg_ff != '0 && 25'(dt_full) > two_avg) ? two_avg[21:0] : dt_full;
   assign sum9       = 28'({avg_ff, 3'b000}) + 28'(avg_ff) + 28'(dt_clamped);
   assign q_prod     = 57'(sum9) * 57'(RecipTen);
   assign q_est      = q_prod[56:32];
   assign q_tens     = 28'({q_est, 3'b000}) + 28'({q_est, 1'b0});
   assign q_rem      = sum9 - q_tens;
   assign q_fix      = (q_rem >= 28'd10) ? q_est + 25'd1 : q_est;
   assign avg_upd    = (avg_ff == '0) ? 24'(dt_clamped) : q_fix[23:0];

   // floor and streak compares
   logic [23:0] floor16;
   logic [27:0] avg10;
   logic [27:0] floor9;
   logic        floor_active;
   logic [35:0] scaled;
   logic [33:0] late_lim;
   logic [33:0] early_lim;
   logic        is_late;
   logic        is_early;

   assign floor16      = {floor_period_ff, 4'b0000};
   assign avg10        = 28'({avg_ff, 3'b000}) + 28'({avg_ff, 1'b0});
   assign floor9       = 28'({floor16, 3'b000}) + 28'(floor16);
   assign floor_active = (floor_period_ff != '0) && (avg_ff != '0);
   assign scaled       = {item_ff.last_delay_us, 12'b0};
   assign late_lim     = 34'(late_ratio_ff) * 34'(avg_ff);
   assign early_lim    = 34'(early_ratio_ff) * 34'(avg_ff);
   assign is_late      = scaled > 36'(late_lim);
   assign is_early     = scaled < 36'(early_lim);

   // ordinal divisibility for each possible step: nibble fold, then reciprocal
   logic [15:0] divisible;

   for (genvar k = 0; k < 16; k++) begin : g_div
      if (k >= 2 && k <= MAX_STEP) begin : g_mod
         localparam int Div   = k;
         localparam int Recip = ((1 << 20) + Div - 1) / Div;
         localparam int Weight [8] = '{1 % Div, 16 % Div, 256 % Div, 4096 % Div,
                                       65536 % Div, 1048576 % Div, 16777216 % Div,
                                       268435456 % Div};
         logic [10:0] fold;
         logic [30:0] prod;
         logic [10:0] quot;
         logic [10:0] rem;

         always_comb begin
            fold = '0;
            for (int i = 0; i < 8; i++) begin
               fold = fold + 11'(item_ff.frame_ordinal[4*i +: 4]) * 11'(Weight[i]);
            end
         end

         assign prod = 31'(fold) * 31'(Recip);
         assign quot = prod[30:20];
         assign rem  = fold - 11'(quot * 11'(Div));
         assign divisible[k] = (rem == '0);
      end else begin : g_one
         assign divisible[k] = 1'b1;
      end
   end

   // next state and result
   logic allow;
   logic changed;
   logic deny;
   logic blocked;

   always_comb begin
      last_time_in  = last_time_ff;
      seen_in       = seen_ff;
      avg_in        = avg_ff;
      presents_in   = presents_ff;
      floor_flag_in = floor_flag_ff;
      late_run_in   = late_run_ff;
      early_run_in  = early_run_ff;
      gov_step_in   = gov_step_ff;
      denied_in     = denied_ff;
      allow         = 1'b0;
      changed       = 1'b0;
      deny          = 1'b0;
      blocked       = 1'b0;
      if (advance) begin
         if (item_ff.mode == MODE_PRESENT) begin
            presents_in = presents_ff + 32'd1;
            if (item_ff.time_valid) begin
               if (seen_ff && dt_us < LongGapUs) begin
                  avg_in = avg_upd;
               end
               last_time_in = item_ff.timestamp_us;
               seen_in      = 1'b1;
            end
         end else begin
            if (floor_active) begin
               if (!floor_flag_ff && avg_ff > floor16) begin
                  floor_flag_in = 1'b1;
               end else if (floor_flag_ff && avg10 < floor9) begin
                  floor_flag_in = 1'b0;
                  late_run_in   = '0;
                  early_run_in  = '0;
               end
               if (floor_flag_in) begin
                  deny    = 1'b1;
                  blocked = 1'b1;
               end
            end
            if (!blocked) begin
               if (!gov_enable_ff || avg_ff == '0) begin
                  allow = 1'b1;
               end else begin
                  if (is_late) begin
                     early_run_in = '0;
                     late_run_in  = (late_run_in == RunMax) ? RunMax : late_run_in + 8'd1;
                     if (late_run_in >= late_frames_ff && gov_step_ff < MaxStep) begin
                        gov_step_in = gov_step_ff + 4'd1;
                        late_run_in = '0;
                     end
                  end else if (is_early) begin
                     late_run_in  = '0;
                     early_run_in = (early_run_in == RunMax) ? RunMax : early_run_in + 8'd1;
                     if (early_run_in >= early_frames_ff && gov_step_ff != '0) begin
                        gov_step_in  = gov_step_ff - 4'd1;
                        early_run_in = '0;
                     end
                  end
                  changed = (gov_step_in != gov_step_ff);
                  if (divisible[gov_step_in]) begin
                     allow = 1'b1;
                  end else begin
                     deny = 1'b1;
                  end
               end
            end
            if (deny && denied_ff != CountMax) begin
               denied_in = denied_ff + 32'd1;
            end
         end
      end
   end

   always_comb begin
      rsp_in.allow          = allow;
      rsp_in.step           = gov_step_in;
      rsp_in.step_changed   = changed;
      rsp_in.below_floor    = floor_flag_in;
      rsp_in.frame_average  = avg_in;
      rsp_in.present_number = presents_in;
      rsp_in.thinned_count  = denied_in;
   end

   `FCG_ASSERT_SAME(a_step_limit, clock, reset, 1'b1, gov_step_ff <= MaxStep, "step above limit")
   `FCG_ASSERT_NEXT(a_present_keeps_step, clock, reset, advance && item_ff.mode == MODE_PRESENT, gov_step_ff == $past(gov_step_ff), "present moved step")
   `FCG_ASSERT_NEXT(a_thinned_monotonic, clock, reset, 1'b1, denied_ff >= $past(denied_ff), "thinned count fell")

endmodule

### dv/frame_cadence_governor_unit_tb.sv
`timescale 1ns / 1ps

module frame_cadence_governor_unit_tb;
   import fcg_pkg::*;

   localparam int MaxStep = 3;
   localparam int IdlePct = 27;
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 50;
   localparam logic [CsrIndexWidth-1:0] CsrSpare = 3'd7;

   typedef struct packed {
      logic                     is_csr;
      logic [CsrIndexWidth-1:0] reg_index;
      logic [CsrDataWidth-1:0]  reg_data;
      req_type                  item;
      logic                     typed;
      rsp_type                  want;
   } plan_row_type;

   logic clock;
   logic reset;

   fcg_req_if req_chan ();
   fcg_rsp_if rsp_chan ();
   fcg_csr_if csr_chan ();

   frame_cadence_governor_unit #(
      .MAX_STEP(MaxStep)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // governor settings as last written
   logic [19:0] cfg_floor_us = 20'd0;
   logic        cfg_gov_on = 1'b1;
   logic [9:0]  cfg_late_ratio = 10'd230;
   logic [9:0]  cfg_early_ratio = 10'd128;
   logic [7:0]  cfg_late_len = 8'd3;
   logic [7:0]  cfg_early_len = 8'd30;

   // cadence state mirror
   logic [31:0] stamp_prev = '0;
   logic        stamp_seen = 1'b0;
   logic [23:0] avg_q4 = '0;
   logic [31:0] present_total = '0;
   logic        floor_hold = 1'b0;
   logic [7:0]  late_tally = '0;
   logic [7:0]  early_tally = '0;
   logic [3:0]  gov_level = '0;
   logic [31:0] deny_total = '0;

   rsp_type     expect_q[$];
   int          open_count = 0;
   rsp_type     head_rsp;
   int          fail_count = 0;
   int          result_index = 0;
   int          idle_pct = IdlePct;

   logic [31:0] stamp_now;
   logic [31:0] ordinal_next;
   int unsigned frame_us = 16000;

   int          presents_sent = 0;
   int          decides_sent = 0;
   int          thinned_seen = 0;
   int          floor_denials = 0;
   int          step_moves = 0;

   plan_row_type plan[$];
   logic        csr_open;
   logic [19:0] floor_pick;
   logic [9:0]  late_pick;
   logic [9:0]  early_pick;
   logic [7:0]  late_len_pick;
   logic [7:0]  early_len_pick;
   logic        gov_pick;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic rsp_type govern_item(req_type it);
      rsp_type     r;
      logic [31:0] dt_us;
      logic [63:0] dt;
      logic [63:0] avg;
      logic [63:0] floor16;
      logic [63:0] scaled;
      logic [63:0] every;
      logic [3:0]  prior;
      r = '0;
      if (it.mode == MODE_PRESENT) begin
         if (it.time_valid) begin
            if (stamp_seen) begin
               dt_us = it.timestamp_us - stamp_prev;
               if (dt_us < LongGapUs) begin
                  dt = 64'(dt_us) * 64'd16;
                  avg = 64'(avg_q4);
                  if (avg != 0 && dt > 2 * avg) dt = 2 * avg;
                  avg = (avg == 0) ? dt : (avg * 9 + dt) / 10;
                  avg_q4 = avg[23:0];
               end
            end
            stamp_prev = it.timestamp_us;
            stamp_seen = 1'b1;
         end
         present_total = present_total + 32'd1;
      end else begin
         avg = 64'(avg_q4);
         prior = gov_level;
         r.allow = 1'b1;
         if (cfg_floor_us != 0 && avg != 0) begin
            floor16 = 64'(cfg_floor_us) * 64'd16;
            if (!floor_hold && avg > floor16) begin
               floor_hold = 1'b1;
            end else if (floor_hold && avg * 10 < floor16 * 9) begin
               floor_hold = 1'b0;
               late_tally = '0;
               early_tally = '0;
            end
            if (floor_hold) r.allow = 1'b0;
         end
         if (r.allow && cfg_gov_on && avg != 0) begin
            scaled = 64'(it.last_delay_us) * 64'd4096;
            if (scaled > 64'(cfg_late_ratio) * avg) begin
               early_tally = '0;
               if (late_tally != RunMax) late_tally = late_tally + 8'd1;
               if (late_tally >= cfg_late_len && gov_level < MaxStep) begin
                  gov_level = gov_level + 4'd1;
                  late_tally = '0;
               end
            end else if (scaled < 64'(cfg_early_ratio) * avg) begin
               late_tally = '0;
               if (early_tally != RunMax) early_tally = early_tally + 8'd1;
               if (early_tally >= cfg_early_len && gov_level > 0) begin
                  gov_level = gov_level - 4'd1;
                  early_tally = '0;
               end
            end
            r.step_changed = (gov_level != prior);
            every = (gov_level >= 2) ? 64'(gov_level) : 64'd1;
            if (64'(it.frame_ordinal) % every != 0) r.allow = 1'b0;
         end
         if (!r.allow && deny_total != CountMax) deny_total = deny_total + 32'd1;
      end
      r.step = gov_level;
      r.below_floor = floor_hold;
      r.frame_average = avg_q4;
      r.present_number = present_total;
      r.thinned_count = deny_total;
      return r;
   endfunction

   function automatic void apply_setting(logic [CsrIndexWidth-1:0] idx,
                                         logic [CsrDataWidth-1:0] val);
      case (idx)
         CSR_FLOOR_PERIOD: cfg_floor_us = val[19:0];
         CSR_GOV_ENABLE:   cfg_gov_on = val[0];
         CSR_LATE_RATIO:   cfg_late_ratio = val[9:0];
         CSR_EARLY_RATIO:  cfg_early_ratio = val[9:0];
         CSR_LATE_FRAMES:  cfg_late_len = val[7:0];
         CSR_EARLY_FRAMES: cfg_early_len = val[7:0];
         default: ;
      endcase
   endfunction

   function automatic plan_row_type item_row(logic mode, logic tv, logic [31:0] ts,
                                             logic [23:0] dly, logic [31:0] ord);
      plan_row_type row;
      row = '0;
      row.item.mode = mode;
      row.item.time_valid = tv;
      row.item.timestamp_us = ts;
      row.item.last_delay_us = dly;
      row.item.frame_ordinal = ord;
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [CsrIndexWidth-1:0] idx,
                                            logic [CsrDataWidth-1:0] val);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.reg_index = idx;
      row.reg_data = val;
      return row;
   endfunction

   // mostly steady cadence with hitches, long gaps, dropped stamps and noise
   function automatic req_type make_item();
      req_type     it;
      int unsigned roll;
      int unsigned gap;
      it.mode = MODE_DECIDE;
      it.time_valid = 1'($urandom_range(1));
      it.timestamp_us = $urandom;
      it.last_delay_us = 24'($urandom);
      it.frame_ordinal = $urandom;
      if ($urandom_range(99) < 40) begin
         it.mode = MODE_PRESENT;
         it.time_valid = ($urandom_range(19) != 0);
         if ($urandom_range(99) < 3) frame_us = $urandom_range(3000, 40000);
         roll = $urandom_range(99);
         if (roll < 3) gap = LongGapUs + $urandom_range(50000);
         else if (roll < 5) gap = $urandom;
         else if (roll < 10) gap = frame_us * $urandom_range(3, 6);
         else gap = frame_us * $urandom_range(80, 120) / 100;
         stamp_now = stamp_now + gap;
         it.timestamp_us = stamp_now;
      end else begin
         roll = $urandom_range(99);
         if (roll >= 10) it.last_delay_us = 24'($urandom_range(2 * frame_us));
         else if (roll >= 5) it.last_delay_us = '0;
         if ($urandom_range(9) != 0) begin
            ordinal_next = ordinal_next + 1;
            it.frame_ordinal = ordinal_next;
         end
      end
      return it;
   endfunction

   task automatic run_item(req_type it, logic typed, rsp_type want);
      rsp_type predicted;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= it;
      do @(posedge clock); while (!req_chan.ready);
      predicted = govern_item(it);
      expect_q.push_back(typed ? want : predicted);
      open_count++;
      if (it.mode == MODE_PRESENT) begin
         presents_sent++;
      end else begin
         decides_sent++;
         if (predicted.step_changed) step_moves++;
         if (!predicted.allow && predicted.below_floor) floor_denials++;
         else if (!predicted.allow) thinned_seen++;
      end
   endtask

   task automatic settle_results();
      req_chan.valid <= 1'b0;
      wait (open_count == 0);
      @(posedge clock);
   endtask

   task automatic csr_put(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      apply_setting(idx, val);
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (open_count == 0) begin
            if (fail_count < 10) $display("result %0d arrived with nothing pending", result_index);
            fail_count++;
         end else begin
            head_rsp = expect_q.pop_front();
            open_count--;
            if (rsp_chan.payload.allow !== head_rsp.allow ||
                rsp_chan.payload.step !== head_rsp.step ||
                rsp_chan.payload.step_changed !== head_rsp.step_changed ||
                rsp_chan.payload.below_floor !== head_rsp.below_floor ||
                rsp_chan.payload.frame_average !== head_rsp.frame_average ||
                rsp_chan.payload.present_number !== head_rsp.present_number ||
                rsp_chan.payload.thinned_count !== head_rsp.thinned_count) begin
               if (fail_count < 10) begin
                  $display("result %0d mismatch (expected/actual):", result_index);
                  $display("  allow %0d/%0d step %0d/%0d changed %0d/%0d floor %0d/%0d",
                           head_rsp.allow, rsp_chan.payload.allow,
                           head_rsp.step, rsp_chan.payload.step,
                           head_rsp.step_changed, rsp_chan.payload.step_changed,
                           head_rsp.below_floor, rsp_chan.payload.below_floor);
                  $display("  average %0h/%0h presents %0h/%0h thinned %0h/%0h",
                           head_rsp.frame_average, rsp_chan.payload.frame_average,
                           head_rsp.present_number, rsp_chan.payload.present_number,
                           head_rsp.thinned_count, rsp_chan.payload.thinned_count);
               end
               fail_count++;
            end
         end
         result_index++;
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= '0;
      csr_chan.data <= '0;
      csr_open = 1'b0;

      // reset defaults, stamp wrap, long gap, hitch, streaks up to the top step
      plan.push_back(item_row(MODE_DECIDE, 1'b0, 32'h0, 24'hFFFFFF, 32'hFFFF_FFFF));
      plan[$].typed = 1'b1;
      plan[$].want.allow = 1'b1;
      plan.push_back(item_row(MODE_PRESENT, 1'b0, 32'hFFFF_FFFF, 24'h0, 32'h0));
      plan[$].typed = 1'b1;
      plan[$].want.present_number = 32'd1;
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'hFFFF_FFF0, 24'h0, 32'h0));
      plan[$].typed = 1'b1;
      plan[$].want.present_number = 32'd2;
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'd16368, 24'h0, 32'h0));
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'd266368, 24'h0, 32'h0));
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'd516367, 24'h0, 32'h0));
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'd516367, 24'h0, 32'h0));
      plan.push_back(item_row(MODE_PRESENT, 1'b0, 32'h1234_5678, 24'h0, 32'h0));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'h0, 32'd0));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd1));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd2));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd3));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd5));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd6));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd7));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd9));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'hFFFF_FFFF));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd1));
      plan.push_back(csr_row(CSR_EARLY_FRAMES, 20'd1));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'h0, 32'd4));
      plan.push_back(csr_row(CSR_GOV_ENABLE, 20'd0));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'hFFFFFF, 32'd1));
      plan.push_back(csr_row(CSR_FLOOR_PERIOD, 20'd1));
      plan.push_back(csr_row(CsrSpare, 20'hFFFFF));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'h000100, 32'd8));
      plan.push_back(item_row(MODE_PRESENT, 1'b1, 32'd524367, 24'h0, 32'h0));
      plan.push_back(csr_row(CSR_FLOOR_PERIOD, 20'd1000000));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'h000100, 32'd3));
      plan.push_back(csr_row(CSR_GOV_ENABLE, 20'd1));
      plan.push_back(item_row(MODE_DECIDE, 1'b1, 32'h0, 24'h0, 32'd3));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!csr_open) settle_results();
            csr_put(plan[i].reg_index, plan[i].reg_data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) csr_chan.valid <= 1'b0;
            csr_open = 1'b0;
            run_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      stamp_now = $urandom;
      ordinal_next = $urandom;
      for (int p = 0; p < PhaseCount; p++) begin
         settle_results();
         case (p)
            0: begin
               floor_pick = 20'd0; gov_pick = 1'b1; late_pick = 10'd230;
               early_pick = 10'd128; late_len_pick = 8'd3; early_len_pick = 8'd30;
            end
            1: begin
               floor_pick = 20'd16667; gov_pick = 1'b1; late_pick = 10'd230;
               early_pick = 10'd128; late_len_pick = 8'd1; early_len_pick = 8'd1;
            end
            2: begin
               floor_pick = 20'd1000000; gov_pick = 1'b1; late_pick = 10'd1023;
               early_pick = 10'd1023; late_len_pick = 8'd255; early_len_pick = 8'd255;
            end
            3: begin
               floor_pick = 20'd0; gov_pick = 1'b0; late_pick = 10'd0;
               early_pick = 10'd0; late_len_pick = 8'd1; early_len_pick = 8'd1;
            end
            4: begin
               floor_pick = 20'd1; gov_pick = 1'b1; late_pick = 10'd0;
               early_pick = 10'd0; late_len_pick = 8'd2; early_len_pick = 8'd2;
            end
            default: begin
               floor_pick = ($urandom_range(3) == 0) ? 20'd0 : 20'($urandom_range(3000, 40000));
               gov_pick = ($urandom_range(4) != 0);
               late_pick = 10'($urandom_range(128, 400));
               early_pick = 10'($urandom_range(32, 200));
               late_len_pick = 8'($urandom_range(1, 6));
               early_len_pick = 8'($urandom_range(1, 12));
            end
         endcase
         csr_put(CSR_FLOOR_PERIOD, floor_pick);
         csr_put(CSR_GOV_ENABLE, 20'(gov_pick));
         csr_put(CSR_LATE_RATIO, 20'(late_pick));
         csr_put(CSR_EARLY_RATIO, 20'(early_pick));
         csr_put(CSR_LATE_FRAMES, 20'(late_len_pick));
         csr_put(CSR_EARLY_FRAMES, 20'(early_len_pick));
         csr_chan.valid <= 1'b0;
         // one phase with both sides running flat out
         idle_pct = (p == 5) ? 0 : IdlePct;
         frame_us = $urandom_range(4000, 33000);
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 1 && n == PhaseItems / 2) settle_results();
            run_item(make_item(), 1'b0, '0);
         end
      end

      settle_results();
      repeat (8) @(posedge clock);

      $display("covered %0d presents and %0d decisions over %0d governor settings",
               presents_sent, decides_sent, PhaseCount);
      $display("%0d thinned, %0d floor denials, %0d step moves, %0d failures",
               thinned_seen, floor_denials, step_moves, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### frame_cadence_governor_unit.f
+incdir+rtl
rtl/fcg_pkg.sv
rtl/fcg_req_if.sv
rtl/fcg_rsp_if.sv
rtl/fcg_csr_if.sv
rtl/frame_cadence_governor_unit.sv
dv/frame_cadence_governor_unit_tb.sv
